>>> hdl/hcrp_pkg.sv
// Shared types and constants for the configuration record parser.
// Holds event codes, header field ids, the result record and the queue entry.
// No dependencies.
`default_nettype none

package hcrp_pkg;

  // Header geometry
  localparam int unsigned HdrLen = 23;

  // Result event codes
  typedef enum logic [2:0] {
    EV_HDR      = 3'd0,
    EV_ARRAY    = 3'd1,
    EV_LENGTH   = 3'd2,
    EV_PAYLOAD  = 3'd3,
    EV_COMPLETE = 3'd4,
    EV_TRUNC    = 3'd5
  } ev_e;

  // Header field ids in record order
  localparam logic [4:0] FID_VERSION        = 5'd0;
  localparam logic [4:0] FID_PROFILE_SPACE  = 5'd1;
  localparam logic [4:0] FID_TIER           = 5'd2;
  localparam logic [4:0] FID_PROFILE_IDC    = 5'd3;
  localparam logic [4:0] FID_COMPAT         = 5'd4;
  localparam logic [4:0] FID_CONSTRAINT     = 5'd5;
  localparam logic [4:0] FID_LEVEL          = 5'd6;
  localparam logic [4:0] FID_MIN_SEG        = 5'd7;
  localparam logic [4:0] FID_PARALLELISM    = 5'd8;
  localparam logic [4:0] FID_CHROMA_FORMAT  = 5'd9;
  localparam logic [4:0] FID_DEPTH_LUMA     = 5'd10;
  localparam logic [4:0] FID_DEPTH_CHROMA   = 5'd11;
  localparam logic [4:0] FID_AVG_RATE       = 5'd12;
  localparam logic [4:0] FID_CONST_RATE     = 5'd13;
  localparam logic [4:0] FID_TEMP_LAYERS    = 5'd14;
  localparam logic [4:0] FID_TEMP_NESTED    = 5'd15;
  localparam logic [4:0] FID_LENGTH_SIZE    = 5'd16;
  localparam logic [4:0] FID_NUM_ARRAYS     = 5'd17;

  // How one primary result fans out into several header fields
  typedef enum logic [1:0] {
    SPLIT_NONE    = 2'd0,
    SPLIT_PROFILE = 2'd1,
    SPLIT_FRAME   = 2'd2
  } split_e;

  // One result record
  typedef struct packed {
    ev_e         ev;
    logic [4:0]  field_id;
    logic [47:0] field_value;
    logic        array_complete;
    logic [5:0]  nal_type;
    logic [15:0] unit_count;
    logic [15:0] unit_length;
    logic [7:0]  payload_byte;
  } result_t;

  // All results caused by one input byte, in compact form
  typedef struct packed {
    logic    prim_valid;
    result_t prim;       // for split entries field_value[7:0] carries the byte
    split_e  split;
    logic    complete;
    logic    trunc;
  } entry_t;

  // Queue status toward the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int unsigned TdataW = 104;

endpackage

`default_nettype wire

>>> hdl/hcrp_front.sv
// Front part of the record parser: walks header, arrays, units and payload.
// Emits one queue entry per byte that causes results. Uses hcrp_pkg.
`default_nettype none

module hcrp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            eor_i,
  output      logic            push_o,
  output      hcrp_pkg::entry_t entry_o
);

  typedef enum logic [4:0] {
    PH_HDR  = 5'b00001,
    PH_ARR  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  // Header byte positions that close a field
  localparam logic [4:0] POS_VERSION      = 5'd0;
  localparam logic [4:0] POS_PROFILE      = 5'd1;
  localparam logic [4:0] POS_COMPAT_END   = 5'd5;
  localparam logic [4:0] POS_CONSTR_END   = 5'd11;
  localparam logic [4:0] POS_LEVEL        = 5'd12;
  localparam logic [4:0] POS_SEG_END      = 5'd14;
  localparam logic [4:0] POS_PARALLELISM  = 5'd15;
  localparam logic [4:0] POS_CHROMA       = 5'd16;
  localparam logic [4:0] POS_DEPTH_LUMA   = 5'd17;
  localparam logic [4:0] POS_DEPTH_CHROMA = 5'd18;
  localparam logic [4:0] POS_RATE_END     = 5'd20;
  localparam logic [4:0] POS_FRAME        = 5'd21;
  localparam logic [4:0] POS_NUM_ARRAYS   = 5'(hcrp_pkg::HdrLen - 1);

  // Byte position inside an array header or unit length
  localparam logic [1:0] SUB_FIRST  = 2'd0;
  localparam logic [1:0] SUB_SECOND = 2'd1;

  phase_e      phase_q, phase_d;
  logic [4:0]  hpos_q, hpos_d;
  logic [47:0] acc_q, acc_d;
  logic [7:0]  arrays_q, arrays_d;
  logic [15:0] units_q, units_d;
  logic [15:0] paylen_q, paylen_d;
  logic [1:0]  sub_q, sub_d;
  logic [6:0]  atype_q, atype_d;

  logic [47:0] acc_shift;
  logic [7:0]  arr_dec;
  logic [15:0] unit_dec;
  logic [15:0] pay_dec;
  logic [15:0] word16;
  logic        fin_unit;
  logic        fin_arr;
  hcrp_pkg::entry_t entry;

  // Parse one byte
  always_comb begin
    phase_d  = phase_q;
    hpos_d   = hpos_q;
    acc_d    = acc_q;
    arrays_d = arrays_q;
    units_d  = units_q;
    paylen_d = paylen_q;
    sub_d    = sub_q;
    atype_d  = atype_q;
    entry    = '0;
    fin_unit = 1'b0;
    fin_arr  = 1'b0;

    acc_shift = {acc_q[39:0], byte_i};
    arr_dec   = arrays_q - 8'd1;
    unit_dec  = units_q - 16'd1;
    pay_dec   = paylen_q - 16'd1;
    word16    = {acc_q[7:0], byte_i};

    case (phase_q)
      PH_HDR: begin
        hpos_d = hpos_q + 5'd1;
        acc_d  = 48'd0;
        entry.prim_valid = 1'b1;
        entry.prim.ev    = hcrp_pkg::EV_HDR;
        case (hpos_q)
          POS_VERSION: begin
            entry.prim.field_id    = hcrp_pkg::FID_VERSION;
            entry.prim.field_value = {40'd0, byte_i};
          end
          POS_PROFILE: begin
            entry.split            = hcrp_pkg::SPLIT_PROFILE;
            entry.prim.field_value = {40'd0, byte_i};
          end
          POS_COMPAT_END: begin
            entry.prim.field_id    = hcrp_pkg::FID_COMPAT;
            entry.prim.field_value = {16'd0, acc_shift[31:0]};
          end
          POS_CONSTR_END: begin
            entry.prim.field_id    = hcrp_pkg::FID_CONSTRAINT;
            entry.prim.field_value = acc_shift;
          end
          POS_LEVEL: begin
            entry.prim.field_id    = hcrp_pkg::FID_LEVEL;
            entry.prim.field_value = {40'd0, byte_i};
          end
          POS_SEG_END: begin
            entry.prim.field_id    = hcrp_pkg::FID_MIN_SEG;
            entry.prim.field_value = {36'd0, acc_shift[11:0]};
          end
          POS_PARALLELISM: begin
            entry.prim.field_id    = hcrp_pkg::FID_PARALLELISM;
            entry.prim.field_value = {46'd0, byte_i[1:0]};
          end
          POS_CHROMA: begin
            entry.prim.field_id    = hcrp_pkg::FID_CHROMA_FORMAT;
            entry.prim.field_value = {46'd0, byte_i[1:0]};
          end
          POS_DEPTH_LUMA: begin
            entry.prim.field_id    = hcrp_pkg::FID_DEPTH_LUMA;
            entry.prim.field_value = {45'd0, byte_i[2:0]};
          end
          POS_DEPTH_CHROMA: begin
            entry.prim.field_id    = hcrp_pkg::FID_DEPTH_CHROMA;
            entry.prim.field_value = {45'd0, byte_i[2:0]};
          end
          POS_RATE_END: begin
            entry.prim.field_id    = hcrp_pkg::FID_AVG_RATE;
            entry.prim.field_value = {32'd0, acc_shift[15:0]};
          end
          POS_FRAME: begin
            entry.split            = hcrp_pkg::SPLIT_FRAME;
            entry.prim.field_value = {40'd0, byte_i};
          end
          POS_NUM_ARRAYS: begin
            entry.prim.field_id    = hcrp_pkg::FID_NUM_ARRAYS;
            entry.prim.field_value = {40'd0, byte_i};
            arrays_d = byte_i;
            sub_d    = SUB_FIRST;
            if (byte_i == 8'd0) begin
              entry.complete = 1'b1;
              phase_d        = PH_DONE;
            end else begin
              phase_d = PH_ARR;
            end
          end
          default: begin
            // byte inside a multi-byte field: keep accumulating
            entry.prim_valid = 1'b0;
            entry.prim       = '0;
            acc_d            = acc_shift;
          end
        endcase
      end

      PH_ARR: begin
        if (sub_q == SUB_FIRST) begin
          atype_d = {byte_i[7], byte_i[5:0]};
          sub_d   = SUB_SECOND;
        end else if (sub_q == SUB_SECOND) begin
          acc_d = {40'd0, byte_i};
          sub_d = sub_q + 2'd1;
        end else begin
          units_d = word16;
          acc_d   = 48'd0;
          sub_d   = SUB_FIRST;
          entry.prim_valid          = 1'b1;
          entry.prim.ev             = hcrp_pkg::EV_ARRAY;
          entry.prim.array_complete = atype_q[6];
          entry.prim.nal_type       = atype_q[5:0];
          entry.prim.unit_count     = word16;
          if (word16 == 16'd0) begin
            fin_arr = 1'b1;
          end else begin
            phase_d = PH_LEN;
          end
        end
      end

      PH_LEN: begin
        if (sub_q == SUB_FIRST) begin
          acc_d = {40'd0, byte_i};
          sub_d = SUB_SECOND;
        end else begin
          paylen_d = word16;
          acc_d    = 48'd0;
          sub_d    = SUB_FIRST;
          entry.prim_valid       = 1'b1;
          entry.prim.ev          = hcrp_pkg::EV_LENGTH;
          entry.prim.nal_type    = atype_q[5:0];
          entry.prim.unit_length = word16;
          if (word16 == 16'd0) begin
            fin_unit = 1'b1;
          end else begin
            phase_d = PH_PAY;
          end
        end
      end

      PH_PAY: begin
        entry.prim_valid        = 1'b1;
        entry.prim.ev           = hcrp_pkg::EV_PAYLOAD;
        entry.prim.nal_type     = atype_q[5:0];
        entry.prim.payload_byte = byte_i;
        paylen_d = pay_dec;
        if (pay_dec == 16'd0) begin
          fin_unit = 1'b1;
        end
      end

      default: begin
        // record done: drop the byte
      end
    endcase

    // Close the unit, then possibly the array
    if (fin_unit) begin
      units_d = unit_dec;
      sub_d   = SUB_FIRST;
      if (unit_dec == 16'd0) begin
        fin_arr = 1'b1;
      end else begin
        phase_d = PH_LEN;
      end
    end
    if (fin_arr) begin
      arrays_d = arr_dec;
      sub_d    = SUB_FIRST;
      if (arr_dec == 8'd0) begin
        entry.complete = 1'b1;
        phase_d        = PH_DONE;
      end else begin
        phase_d = PH_ARR;
      end
    end

    // End mark: flag truncation and restart
    if (eor_i) begin
      entry.trunc = (phase_q != PH_DONE) && (phase_d != PH_DONE);
      phase_d  = PH_HDR;
      hpos_d   = 5'd0;
      acc_d    = 48'd0;
      arrays_d = 8'd0;
      units_d  = 16'd0;
      paylen_d = 16'd0;
      sub_d    = SUB_FIRST;
      atype_d  = 7'd0;
    end
  end

  assign entry_o = entry;
  assign push_o  = accept_i && (entry.prim_valid || entry.complete || entry.trunc);

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      hpos_q   <= 5'd0;
      acc_q    <= 48'd0;
      arrays_q <= 8'd0;
      units_q  <= 16'd0;
      paylen_q <= 16'd0;
      sub_q    <= SUB_FIRST;
      atype_q  <= 7'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      acc_q    <= acc_d;
      arrays_q <= arrays_d;
      units_q  <= units_d;
      paylen_q <= paylen_d;
      sub_q    <= sub_d;
      atype_q  <= atype_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hcrp_queue.sv
// Short queue of result entries between the parser front and the result back.
// Register array with read and write pointers. Uses hcrp_pkg.
`default_nettype none

module hcrp_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire hcrp_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output      hcrp_pkg::entry_t head_o,
  output      hcrp_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  hcrp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Store pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/hcrp_back.sv
// Back part of the record parser: expands each queue entry into its results
// and holds one result in an output register. Uses hcrp_pkg.
`default_nettype none

module hcrp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire hcrp_pkg::entry_t  head_i,
  output      logic              pop_o,
  output      logic              valid_o,
  input  wire logic              ready_i,
  output      hcrp_pkg::result_t res_o,
  output      logic              last_o
);

  logic [2:0]  idx_q;
  logic [2:0]  nprim;
  logic [2:0]  total;
  logic        is_last;
  logic        load;
  logic [7:0]  hb;
  logic        out_valid_q;
  logic        out_last_q;
  hcrp_pkg::result_t out_q;
  hcrp_pkg::result_t cur;

  assign hb = head_i.prim.field_value[7:0];

  // Count results of the head entry
  always_comb begin
    if (!head_i.prim_valid) begin
      nprim = 3'd0;
    end else begin
      case (head_i.split)
        hcrp_pkg::SPLIT_PROFILE: nprim = 3'd3;
        hcrp_pkg::SPLIT_FRAME:   nprim = 3'd4;
        default:                 nprim = 3'd1;
      endcase
    end
    total   = nprim + {2'd0, head_i.complete} + {2'd0, head_i.trunc};
    is_last = (idx_q == total - 3'd1);
  end

  // Select the result at the current index
  always_comb begin
    cur = '0;
    if (idx_q < nprim) begin
      cur = head_i.prim;
      case (head_i.split)
        hcrp_pkg::SPLIT_PROFILE: begin
          case (idx_q)
            3'd0: begin
              cur.field_id    = hcrp_pkg::FID_PROFILE_SPACE;
              cur.field_value = {46'd0, hb[7:6]};
            end
            3'd1: begin
              cur.field_id    = hcrp_pkg::FID_TIER;
              cur.field_value = {47'd0, hb[5]};
            end
            default: begin
              cur.field_id    = hcrp_pkg::FID_PROFILE_IDC;
              cur.field_value = {43'd0, hb[4:0]};
            end
          endcase
        end
        hcrp_pkg::SPLIT_FRAME: begin
          case (idx_q)
            3'd0: begin
              cur.field_id    = hcrp_pkg::FID_CONST_RATE;
              cur.field_value = {46'd0, hb[7:6]};
            end
            3'd1: begin
              cur.field_id    = hcrp_pkg::FID_TEMP_LAYERS;
              cur.field_value = {45'd0, hb[5:3]};
            end
            3'd2: begin
              cur.field_id    = hcrp_pkg::FID_TEMP_NESTED;
              cur.field_value = {47'd0, hb[2]};
            end
            default: begin
              cur.field_id    = hcrp_pkg::FID_LENGTH_SIZE;
              cur.field_value = {46'd0, hb[1:0]};
            end
          endcase
        end
        default: begin
          cur = head_i.prim;
        end
      endcase
    end else if ((idx_q == nprim) && head_i.complete) begin
      cur.ev = hcrp_pkg::EV_COMPLETE;
    end else begin
      cur.ev = hcrp_pkg::EV_TRUNC;
    end
  end

  assign load  = head_valid_i && (!out_valid_q || ready_i);
  assign pop_o = load && is_last;

  // Step through the entry's results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q      <= cur;
      out_last_q <= is_last;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;
  assign last_o  = out_last_q;

endmodule

`default_nettype wire

>>> hdl/hevc_config_record_parser.sv
// Path: each result goes through the queue and then the single output register.
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is ready; a byte with n results sends them out one at a time.
// The two-entry queue lets bytes that give no result pass while results drain.
// Reset: asynchronous, active low; parser returns to the header phase, queue
// and output register empty. No clearing pass.
`default_nettype none

module hevc_config_record_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic         s_axis_tlast_i,   // end_of_record
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [4:0] field_id, [52:5] field_value, [53] array_complete, [59:54] nal_type,
  // [75:60] unit_count, [91:76] unit_length, [99:92] payload_byte, rest zero
  output      logic [hcrp_pkg::TdataW-1:0] m_axis_tdata_o,
  output      logic [2:0]   m_axis_tuser_o,   // [2:0] event_res
  output      logic         m_axis_tlast_o    // last_of_run
);

  logic               accept;
  logic               push;
  logic               pop;
  hcrp_pkg::entry_t   entry;
  hcrp_pkg::entry_t   head;
  hcrp_pkg::q_stat_t  q_stat;
  hcrp_pkg::result_t  res;

  assign s_axis_tready_o = !q_stat.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  hcrp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .eor_i    (s_axis_tlast_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  hcrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  hcrp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_stat.empty),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .res_o        (res),
    .last_o       (m_axis_tlast_o)
  );

  // Pack the result onto the stream
  assign m_axis_tuser_o = res.ev;
  assign m_axis_tdata_o = {4'd0, res.payload_byte, res.unit_length, res.unit_count,
                           res.nal_type, res.array_complete, res.field_value,
                           res.field_id};

  // Queue is never both full and empty
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  // Push only happens when the queue has room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // Complete and truncated always close their byte's run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res.ev == hcrp_pkg::EV_COMPLETE ||
                         res.ev == hcrp_pkg::EV_TRUNC)) |-> m_axis_tlast_o)
    else $error("end event not last of run");

  // Header fields are zero outside header events
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.ev != hcrp_pkg::EV_HDR) |->
      (res.field_id == 5'd0 && res.field_value == 48'd0))
    else $error("header field set on non-header event");

endmodule

`default_nettype wire
